// ===== rtl/core/ppts_pkg.sv =====
package ppts_pkg;

   // default geometry
   localparam int COORD_BITS_DEFAULT = 24;
   localparam int FRAC_BITS_DEFAULT  = 16;

   // configuration register widths
   localparam int MAX_VEL_BITS   = 20;
   localparam int VEL_STEP_BITS  = 16;
   localparam int IDLE_TIME_BITS = 24;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_VELOCITY      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VELOCITY_STEP     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IDLE_SEGMENT_TIME = 2'd2;

   // configuration reset values
   localparam logic [MAX_VEL_BITS-1:0]   MAX_VEL_RESET   = 20'd14418;
   localparam logic [VEL_STEP_BITS-1:0]  VEL_STEP_RESET  = 16'd655;
   localparam logic [IDLE_TIME_BITS-1:0] IDLE_TIME_RESET = 24'd6554;

   // velocity and time formats
   localparam int VEL_BITS       = 21;
   localparam int TIME_BITS      = 63;
   localparam int TIME_FRAC_BITS = 32;
   localparam int SEC_BITS       = 31;
   localparam int NSEC_BITS      = 30;

   localparam logic [TIME_BITS-1:0] TIME_MAX   = {TIME_BITS{1'b1}};
   localparam logic [NSEC_BITS-1:0] NS_PER_SEC = 30'd1000000000;

endpackage

// ===== rtl/core/path_point_timestamper.sv =====
// path_point_timestamper
// Stamps a stream of 2-D path points (signed Q.FRAC_BITS metres) with the
// time a velocity-ramped vehicle reaches them. A point on the req_ channel
// with req_path_start set (or the first point after reset) opens a path and
// gives no result; every later point gives one result on the rsp_ channel:
// the previous point with the accumulated time as seconds and nanoseconds.
// The last point of a path is never stamped.
// Each point is processed one bit or one digit per cycle: squaring of dx and
// dy, square root, long division of the distance by the velocity (skipped
// at zero velocity), time accumulation and shift-add for the nanoseconds.
// A new point is taken only in the idle state, after the previous one has
// been handed to the output register; a path start leaves the block idle.
// req_stall is high while a point is being worked on. The result sits in an
// output register, so the next point is taken while rsp_stall holds the
// previous result; a new result waits inside until that register frees up.
// Reset (synchronous, active high) restores the register defaults, clears
// the velocity, the elapsed time and the previous point, and empties the
// output register. The csr_ channel is always ready; the user must write it
// only while idle, as the block itself does not enforce this.
module path_point_timestamper #(
   parameter int COORD_BITS = ppts_pkg::COORD_BITS_DEFAULT,
   parameter int FRAC_BITS  = ppts_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // point input
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [COORD_BITS-1:0]         req_pos_x,
   input  logic signed [COORD_BITS-1:0]         req_pos_y,
   input  logic                                 req_path_start,
   // stamped point output
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [COORD_BITS-1:0]         rsp_out_x,
   output logic signed [COORD_BITS-1:0]         rsp_out_y,
   output logic [ppts_pkg::SEC_BITS-1:0]        rsp_stamp_sec,
   output logic [ppts_pkg::NSEC_BITS-1:0]       rsp_stamp_nanosec,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ppts_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ppts_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import ppts_pkg::*;

   localparam int SQ_BITS    = 2 * COORD_BITS + 1;
   localparam int ROOT_BITS  = COORD_BITS + 1;
   localparam int RAD_BITS   = 2 * ROOT_BITS;
   localparam int RREM_BITS  = ROOT_BITS + 2;
   localparam int QUOT_BITS  = ROOT_BITS + TIME_FRAC_BITS;
   localparam int CNT_BITS   = $clog2(QUOT_BITS + 1);
   localparam int IDLE_SHIFT = TIME_FRAC_BITS - FRAC_BITS;

   localparam logic [CNT_BITS-1:0] CNT_SQ_HALF   = CNT_BITS'(COORD_BITS - 1);
   localparam logic [CNT_BITS-1:0] CNT_SQ_LAST   = CNT_BITS'(2 * COORD_BITS - 1);
   localparam logic [CNT_BITS-1:0] CNT_ROOT_LAST = CNT_BITS'(ROOT_BITS - 1);
   localparam logic [CNT_BITS-1:0] CNT_DIV_LAST  = CNT_BITS'(QUOT_BITS - 1);
   localparam logic [CNT_BITS-1:0] CNT_NANO_LAST = CNT_BITS'(TIME_FRAC_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_DIVIDE,
      ST_ACCUM,
      ST_NANO,
      ST_DONE
   } state_type;

   // control state
   state_type                 state_ff,      state_in;
   logic [CNT_BITS-1:0]       cnt_ff,        cnt_in;
   logic                      have_prev_ff,  have_prev_in;
   logic [VEL_BITS-1:0]       velocity_ff,   velocity_in;
   logic [TIME_BITS-1:0]      elapsed_ff,    elapsed_in;
   logic [COORD_BITS-1:0]     prev_x_ff,     prev_x_in;
   logic [COORD_BITS-1:0]     prev_y_ff,     prev_y_in;
   logic                      rsp_valid_ff,  rsp_valid_in;
   logic [MAX_VEL_BITS-1:0]   max_vel_ff,    max_vel_in;
   logic [VEL_STEP_BITS-1:0]  vel_step_ff,   vel_step_in;
   logic [IDLE_TIME_BITS-1:0] idle_time_ff,  idle_time_in;

   // datapath
   logic [COORD_BITS-1:0]     emit_x_ff,     emit_x_in;
   logic [COORD_BITS-1:0]     emit_y_ff,     emit_y_in;
   logic [COORD_BITS-1:0]     mag_y_ff,      mag_y_in;
   logic [COORD_BITS-1:0]     mplier_ff,     mplier_in;
   logic [2*COORD_BITS-1:0]   mcand_ff,      mcand_in;
   logic [SQ_BITS-1:0]        sq_acc_ff,     sq_acc_in;
   logic [RAD_BITS-1:0]       rad_ff,        rad_in;
   logic [RREM_BITS-1:0]      rrem_ff,       rrem_in;
   logic [ROOT_BITS-1:0]      root_ff,       root_in;
   logic [QUOT_BITS-1:0]      dvd_ff,        dvd_in;
   logic [VEL_BITS-1:0]       drem_ff,       drem_in;
   logic [TIME_FRAC_BITS-1:0] frac_ff,       frac_in;
   logic [NSEC_BITS-1:0]      nacc_ff,       nacc_in;
   logic [COORD_BITS-1:0]     out_x_ff,      out_x_in;
   logic [COORD_BITS-1:0]     out_y_ff,      out_y_in;
   logic [SEC_BITS-1:0]       out_sec_ff,    out_sec_in;
   logic [NSEC_BITS-1:0]      out_nsec_ff,   out_nsec_in;

   // combinational helpers
   logic                      req_xfer;
   logic                      out_free;
   logic [COORD_BITS:0]       diff_x;
   logic [COORD_BITS:0]       diff_y;
   logic [COORD_BITS:0]       neg_x;
   logic [COORD_BITS:0]       neg_y;
   logic [COORD_BITS-1:0]     mag_x;
   logic [COORD_BITS-1:0]     mag_y;
   logic [VEL_BITS:0]         vel_sum;
   logic [RREM_BITS+1:0]      rrem_sh;
   logic [RREM_BITS+1:0]      rtrial;
   logic                      rtake;
   logic [VEL_BITS:0]         drem_sh;
   logic                      dtake;
   logic                      quot_sat;
   logic [TIME_BITS-1:0]      seg_dt;
   logic [TIME_BITS:0]        time_sum;
   logic [NSEC_BITS:0]        nsum;

   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_x         = out_x_ff;
   assign rsp_out_y         = out_y_ff;
   assign rsp_stamp_sec     = out_sec_ff;
   assign rsp_stamp_nanosec = out_nsec_ff;

   // coordinate differences and magnitudes
   assign diff_x = {req_pos_x[COORD_BITS-1], req_pos_x} - {prev_x_ff[COORD_BITS-1], prev_x_ff};
   assign diff_y = {req_pos_y[COORD_BITS-1], req_pos_y} - {prev_y_ff[COORD_BITS-1], prev_y_ff};
   assign neg_x  = '0 - diff_x;
   assign neg_y  = '0 - diff_y;
   assign mag_x  = diff_x[COORD_BITS] ? neg_x[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
   assign mag_y  = diff_y[COORD_BITS] ? neg_y[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];

   // velocity ramp, wraps at the velocity width
   assign vel_sum = {1'b0, velocity_ff} + (VEL_BITS + 1)'(vel_step_ff);

   // one root bit per cycle
   assign rrem_sh = {rrem_ff, rad_ff[RAD_BITS-1 -: 2]};
   assign rtrial  = (RREM_BITS + 2)'({root_ff, 2'b01});
   assign rtake   = (rrem_sh >= rtrial);

   // one quotient bit per cycle
   assign drem_sh = {drem_ff, dvd_ff[QUOT_BITS-1]};
   assign dtake   = (drem_sh >= {1'b0, velocity_ff});

   // segment time selection and saturating accumulation
   assign quot_sat = ((dvd_ff >> TIME_BITS) != '0);
   always_comb begin
      if (velocity_ff == '0) begin
         seg_dt = TIME_BITS'(idle_time_ff) << IDLE_SHIFT;
      end else if (quot_sat) begin
         seg_dt = TIME_MAX;
      end else begin
         seg_dt = TIME_BITS'(dvd_ff);
      end
   end
   assign time_sum = {1'b0, elapsed_ff} + {1'b0, seg_dt};

   // shift-add step of fraction times one billion
   assign nsum = {1'b0, nacc_ff} + (frac_ff[0] ? {1'b0, NS_PER_SEC} : '0);

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      have_prev_in = have_prev_ff;
      velocity_in  = velocity_ff;
      elapsed_in   = elapsed_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      max_vel_in   = max_vel_ff;
      vel_step_in  = vel_step_ff;
      idle_time_in = idle_time_ff;
      emit_x_in    = emit_x_ff;
      emit_y_in    = emit_y_ff;
      mag_y_in     = mag_y_ff;
      mplier_in    = mplier_ff;
      mcand_in     = mcand_ff;
      sq_acc_in    = sq_acc_ff;
      rad_in       = rad_ff;
      rrem_in      = rrem_ff;
      root_in      = root_ff;
      dvd_in       = dvd_ff;
      drem_in      = drem_ff;
      frac_in      = frac_ff;
      nacc_in      = nacc_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_sec_in   = out_sec_ff;
      out_nsec_in  = out_nsec_ff;

      // register writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_VELOCITY:      max_vel_in   = csr_data[MAX_VEL_BITS-1:0];
            CSR_VELOCITY_STEP:     vel_step_in  = csr_data[VEL_STEP_BITS-1:0];
            CSR_IDLE_SEGMENT_TIME: idle_time_in = csr_data[IDLE_TIME_BITS-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         // take a point: open a path or start the distance
         ST_IDLE: begin
            if (req_xfer) begin
               prev_x_in = req_pos_x;
               prev_y_in = req_pos_y;
               if (req_path_start || !have_prev_ff) begin
                  have_prev_in = 1'b1;
                  velocity_in  = '0;
                  elapsed_in   = '0;
               end else begin
                  emit_x_in = prev_x_ff;
                  emit_y_in = prev_y_ff;
                  if (velocity_ff < VEL_BITS'(max_vel_ff)) begin
                     velocity_in = vel_sum[VEL_BITS-1:0];
                  end
                  mag_y_in  = mag_y;
                  mplier_in = mag_x;
                  mcand_in  = (2 * COORD_BITS)'(mag_x);
                  sq_acc_in = '0;
                  cnt_in    = '0;
                  state_in  = ST_SQUARE;
               end
            end
         end
         // dx squared then dy squared, one multiplier bit per cycle
         ST_SQUARE: begin
            sq_acc_in = sq_acc_ff + (mplier_ff[0] ? SQ_BITS'(mcand_ff) : '0);
            mplier_in = mplier_ff >> 1;
            mcand_in  = mcand_ff << 1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_SQ_HALF) begin
               mplier_in = mag_y_ff;
               mcand_in  = (2 * COORD_BITS)'(mag_y_ff);
            end
            if (cnt_ff == CNT_SQ_LAST) begin
               rad_in   = RAD_BITS'(sq_acc_in);
               rrem_in  = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = ST_ROOT;
            end
         end
         // restoring square root, two radicand bits per cycle
         ST_ROOT: begin
            rrem_in = rtake ? RREM_BITS'(rrem_sh - rtrial) : RREM_BITS'(rrem_sh);
            root_in = {root_ff[ROOT_BITS-2:0], rtake};
            rad_in  = rad_ff << 2;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_ROOT_LAST) begin
               dvd_in  = {root_in, {TIME_FRAC_BITS{1'b0}}};
               drem_in = '0;
               cnt_in  = '0;
               if (velocity_ff == '0) begin
                  state_in = ST_ACCUM;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         // long division of distance by velocity into Q.32 seconds
         ST_DIVIDE: begin
            drem_in = dtake ? VEL_BITS'(drem_sh - {1'b0, velocity_ff})
                            : VEL_BITS'(drem_sh);
            dvd_in  = {dvd_ff[QUOT_BITS-2:0], dtake};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_DIV_LAST) begin
               cnt_in   = '0;
               state_in = ST_ACCUM;
            end
         end
         // add segment time, saturating
         ST_ACCUM: begin
            elapsed_in = time_sum[TIME_BITS] ? TIME_MAX : time_sum[TIME_BITS-1:0];
            frac_in    = elapsed_in[TIME_FRAC_BITS-1:0];
            nacc_in    = '0;
            cnt_in     = '0;
            state_in   = ST_NANO;
         end
         // fraction times one billion, one fraction bit per cycle
         ST_NANO: begin
            nacc_in = nsum[NSEC_BITS:1];
            frac_in = frac_ff >> 1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_NANO_LAST) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end
         // hand the stamp to the output register once it is free
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_x_in     = emit_x_ff;
               out_y_in     = emit_y_ff;
               out_sec_in   = elapsed_ff[TIME_BITS-1:TIME_FRAC_BITS];
               out_nsec_in  = nacc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      emit_x_ff   <= emit_x_in;
      emit_y_ff   <= emit_y_in;
      mag_y_ff    <= mag_y_in;
      mplier_ff   <= mplier_in;
      mcand_ff    <= mcand_in;
      sq_acc_ff   <= sq_acc_in;
      rad_ff      <= rad_in;
      rrem_ff     <= rrem_in;
      root_ff     <= root_in;
      dvd_ff      <= dvd_in;
      drem_ff     <= drem_in;
      frac_ff     <= frac_in;
      nacc_ff     <= nacc_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_sec_ff  <= out_sec_in;
      out_nsec_ff <= out_nsec_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         have_prev_ff <= 1'b0;
         velocity_ff  <= '0;
         elapsed_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         max_vel_ff   <= MAX_VEL_RESET;
         vel_step_ff  <= VEL_STEP_RESET;
         idle_time_ff <= IDLE_TIME_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         have_prev_ff <= have_prev_in;
         velocity_ff  <= velocity_in;
         elapsed_ff   <= elapsed_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         rsp_valid_ff <= rsp_valid_in;
         max_vel_ff   <= max_vel_in;
         vel_step_ff  <= vel_step_in;
         idle_time_ff <= idle_time_in;
      end
   end

endmodule
